@@ rtl/rlkd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_pkg: shared definitions for the resistor ladder keypad decoder
// Command codes, key phase codes, field widths and the key code map.
// ----------------------------------------------------------------------------
package rlkd_pkg;

	// Table size and ADC resolution
	localparam int MAX_KEYS    = 16;
	localparam int SAMPLE_BITS = 12;
	localparam int KIDX_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int EIDX_W  = 4;
	localparam int KCNT_W  = 5;
	localparam int CODE_W  = 8;
	localparam int PHASE_W = 3;
	localparam int TICK_W  = 8;

	// APB port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Register indexes
	localparam logic [2:0] REG_KEY_COUNT  = 3'd0;
	localparam logic [2:0] REG_TOLERANCE  = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE   = 3'd2;
	localparam logic [2:0] REG_LONG_EN    = 3'd3;
	localparam logic [2:0] REG_LONG_TICKS = 3'd4;

	// Register reset values
	localparam logic [KCNT_W-1:0]      KEY_COUNT_RST  = 5'd16;
	localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RST  = SAMPLE_BITS'(20);
	localparam logic [TICK_W-1:0]      DEBOUNCE_RST   = 8'd4;
	localparam logic [TICK_W-1:0]      LONG_TICKS_RST = 8'd100;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	// Key phase
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_HELD     = 3'd2,
		PH_RELEASED = 3'd3,
		PH_READ     = 3'd4
	} phase_t;

	// Characters
	localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CODE_W-1:0] CHAR_HASH  = 8'h23;
	localparam logic [CODE_W-1:0] CHAR_AT    = 8'h40;
	localparam logic [CODE_W-1:0] CHAR_EQ    = 8'h3D;
	localparam logic [CODE_W-1:0] CHAR_GT    = 8'h3E;
	localparam logic [CODE_W-1:0] CHAR_LT    = 8'h3C;
	localparam logic [CODE_W-1:0] LONG_BIT   = 8'h80;
	localparam logic [TICK_W-1:0] TICK_MAX   = 8'hFF;

	// Table index to ASCII key code
	function automatic logic [CODE_W-1:0] code_for(input logic [3:0] idx);
		logic [CODE_W-1:0] c;
		unique case (idx)
			4'd10:   c = CHAR_STAR;
			4'd11:   c = CHAR_HASH;
			4'd12:   c = CHAR_AT;
			4'd13:   c = CHAR_EQ;
			4'd14:   c = CHAR_GT;
			4'd15:   c = CHAR_LT;
			default: c = CHAR_ZERO + {4'd0, idx};
		endcase
		return c;
	endfunction

endpackage

@@ rtl/resistor_ladder_keypad_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_keypad_decoder_unit: keypad decoder with debounce and hold
// Matches ADC samples against a table of key levels, then debounces, times
// and latches the key until it is read once.
// ----------------------------------------------------------------------------
// Read, write and samples at or below tolerance go from SQ_WAIT to SQ_DONE;
// a scan that searches passes through SQ_SEARCH, one table entry compared
// per cycle in the shared distance/compare unit, up to min(key_count,
// MAX_KEYS) entries. A new item is taken only in SQ_WAIT, once the last
// result is committed; the next may be taken while a result waits.
// Reset: async; sets config reset values, clears table levels and key phase.
module resistor_ladder_keypad_decoder_unit
	import rlkd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CMD_W-1:0]       command,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [EIDX_W-1:0]      entry_index,
	input  logic [SAMPLE_BITS-1:0] entry_value,
	// output channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CODE_W-1:0]      key_code,
	output logic [PHASE_W-1:0]     machine_state,
	// APB configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	typedef enum logic [1:0] {
		SQ_WAIT,
		SQ_SEARCH,
		SQ_DONE
	} seq_t;

	// Configuration registers
	logic [KCNT_W-1:0]      key_count_q;
	logic [SAMPLE_BITS-1:0] tolerance_q;
	logic [TICK_W-1:0]      debounce_ticks_q;
	logic                   long_en_q;
	logic [TICK_W-1:0]      long_ticks_q;

	// Sequencer and item registers
	seq_t                   seq_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [SAMPLE_BITS-1:0] data_q;
	logic [EIDX_W-1:0]      eidx_q;
	logic [KCNT_W-1:0]      idx_q;
	logic [CODE_W-1:0]      match_q;

	// Keypad state
	logic [SAMPLE_BITS-1:0] key_levels_q [MAX_KEYS];
	phase_t                 phase_q;
	logic [CODE_W-1:0]      held_key_q;
	logic [TICK_W-1:0]      debounce_left_q;
	logic [TICK_W-1:0]      hold_ticks_q;

	// Output register
	logic                   out_valid_q;
	logic [CODE_W-1:0]      key_code_q;
	logic [PHASE_W-1:0]     machine_state_q;

	logic                   in_xfer;
	logic                   cfg_wr;
	logic [2:0]             reg_idx;
	logic [KCNT_W-1:0]      n_lim;
	logic [SAMPLE_BITS-1:0] lvl;
	logic [SAMPLE_BITS-1:0] delta;
	logic                   hit;
	logic                   commit;

	assign in_ready      = (seq_q == SQ_WAIT);
	assign in_xfer       = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign key_code      = key_code_q;
	assign machine_state = machine_state_q;
	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready;
	assign reg_idx       = paddr[4:2];
	assign commit        = (seq_q == SQ_DONE) && (!out_valid_q || out_ready);

	// Register read-back
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_KEY_COUNT:  prdata = APB_DW'(key_count_q);
			REG_TOLERANCE:  prdata = APB_DW'(tolerance_q);
			REG_DEBOUNCE:   prdata = APB_DW'(debounce_ticks_q);
			REG_LONG_EN:    prdata = APB_DW'(long_en_q);
			REG_LONG_TICKS: prdata = APB_DW'(long_ticks_q);
			default:        prdata = '0;
		endcase
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q      <= KEY_COUNT_RST;
			tolerance_q      <= TOLERANCE_RST;
			debounce_ticks_q <= DEBOUNCE_RST;
			long_en_q        <= 1'b0;
			long_ticks_q     <= LONG_TICKS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_KEY_COUNT:  key_count_q      <= pwdata[KCNT_W-1:0];
				REG_TOLERANCE:  tolerance_q      <= pwdata[SAMPLE_BITS-1:0];
				REG_DEBOUNCE:   debounce_ticks_q <= pwdata[TICK_W-1:0];
				REG_LONG_EN:    long_en_q        <= pwdata[0];
				REG_LONG_TICKS: long_ticks_q     <= pwdata[TICK_W-1:0];
				default:        ;
			endcase
		end
	end

	// Shared distance/compare unit: one table entry per cycle
	always_comb begin
		n_lim = (key_count_q > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : key_count_q;
		lvl   = key_levels_q[idx_q[KIDX_W-1:0]];
		delta = (data_q >= lvl) ? (data_q - lvl) : (lvl - data_q);
		hit   = (delta <= tolerance_q);
	end

	// Sequencer, keypad state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q           <= SQ_WAIT;
			phase_q         <= PH_IDLE;
			held_key_q      <= '0;
			debounce_left_q <= '0;
			hold_ticks_q    <= '0;
			out_valid_q     <= 1'b0;
			cmd_q           <= CMD_SCAN;
			idx_q           <= '0;
			match_q         <= '0;
			for (int i = 0; i < MAX_KEYS; i++) begin
				key_levels_q[i] <= '0;
			end
		end else begin
			// result taken and nothing new to hand over
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (seq_q)
				SQ_WAIT: begin
					if (in_xfer) begin
						cmd_q   <= command;
						data_q  <= (command == CMD_WRITE) ? entry_value : sample;
						eidx_q  <= entry_index;
						idx_q   <= '0;
						match_q <= '0;
						// only a scan above tolerance walks the table
						if (command == CMD_SCAN && sample > tolerance_q) begin
							seq_q <= SQ_SEARCH;
						end else begin
							seq_q <= SQ_DONE;
						end
					end
				end
				SQ_SEARCH: begin
					if (idx_q >= n_lim) begin
						seq_q <= SQ_DONE;
					end else if (hit) begin
						match_q <= code_for(idx_q[3:0]);
						seq_q   <= SQ_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				SQ_DONE: begin
					if (commit) begin
						phase_t nph;
						logic [CODE_W-1:0] code;
						nph  = phase_q;
						code = '0;
						case (cmd_q)
							CMD_SCAN: begin
								unique case (phase_q)
									PH_IDLE: begin
										if (match_q != '0) begin
											held_key_q      <= match_q;
											debounce_left_q <= debounce_ticks_q;
											hold_ticks_q    <= '0;
											nph             = PH_DEBOUNCE;
										end
									end
									PH_DEBOUNCE: begin
										if (match_q == held_key_q) begin
											if (debounce_left_q != '0) begin
												debounce_left_q <= debounce_left_q - 1'b1;
											end else begin
												hold_ticks_q <= '0;
												nph          = PH_HELD;
											end
										end else begin
											nph = PH_IDLE;
										end
									end
									PH_HELD: begin
										if (match_q != held_key_q) begin
											nph = PH_RELEASED;
										end else if (hold_ticks_q != TICK_MAX) begin
											hold_ticks_q <= hold_ticks_q + 1'b1;
										end
									end
									PH_RELEASED: ;
									default: nph = PH_IDLE;
								endcase
							end
							CMD_READ: begin
								if (phase_q == PH_RELEASED) begin
									nph  = PH_READ;
									code = held_key_q;
									if (long_en_q && hold_ticks_q > long_ticks_q) begin
										code = code | LONG_BIT;
									end
								end
							end
							CMD_WRITE: begin
								if ({1'b0, eidx_q} < (EIDX_W + 1)'(MAX_KEYS)) begin
									key_levels_q[eidx_q[KIDX_W-1:0]] <= data_q;
								end
							end
							default: ;
						endcase
						phase_q         <= nph;
						key_code_q      <= code;
						machine_state_q <= nph;
						out_valid_q     <= 1'b1;
						seq_q           <= SQ_WAIT;
					end
				end
				default: seq_q <= SQ_WAIT;
			endcase
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the resistor ladder keypad decoder
// Drives scan, read and table write transfers with bursty valid and a
// stalling receiver, and sweeps the config registers over APB between
// phases. A shadow of the keypad state predicts each result, and every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import rlkd_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int DRAIN_WAIT  = MAX_KEYS + 4;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int N_PHASES    = 7;

	// Predicted result of one item
	typedef struct packed {
		logic [CODE_W-1:0] code;
		phase_t            phase_after;
	} key_result_t;

	// Shadow of the keypad state and registers, plus the pending results
	class keypad_shadow;
		logic [SAMPLE_BITS-1:0] levels [MAX_KEYS];
		phase_t                 key_phase;
		logic [CODE_W-1:0]      latched_key;
		logic [TICK_W-1:0]      debounce_left;
		logic [TICK_W-1:0]      hold_count;
		logic [KCNT_W-1:0]      key_count;
		logic [SAMPLE_BITS-1:0] tolerance;
		logic [TICK_W-1:0]      debounce_ticks;
		logic                   long_en;
		logic [TICK_W-1:0]      long_ticks;
		key_result_t            expected_keys [$];
		int                     errors;

		function new();
			foreach (levels[i]) levels[i] = '0;
			key_phase      = PH_IDLE;
			latched_key    = '0;
			debounce_left  = '0;
			hold_count     = '0;
			key_count      = KEY_COUNT_RST;
			tolerance      = TOLERANCE_RST;
			debounce_ticks = DEBOUNCE_RST;
			long_en        = 1'b0;
			long_ticks     = LONG_TICKS_RST;
			errors         = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [APB_DW-1:0] v);
			case (idx)
				REG_KEY_COUNT:  key_count      = v[KCNT_W-1:0];
				REG_TOLERANCE:  tolerance      = v[SAMPLE_BITS-1:0];
				REG_DEBOUNCE:   debounce_ticks = v[TICK_W-1:0];
				REG_LONG_EN:    long_en        = v[0];
				REG_LONG_TICKS: long_ticks     = v[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CODE_W-1:0] key_char(int i);
			case (i)
				10:      return CHAR_STAR;
				11:      return CHAR_HASH;
				12:      return CHAR_AT;
				13:      return CHAR_EQ;
				14:      return CHAR_GT;
				15:      return CHAR_LT;
				default: return CHAR_ZERO + CODE_W'(i);
			endcase
		endfunction

		// First table entry within tolerance; samples at or below it mean no key
		function logic [CODE_W-1:0] decode_sample(logic [SAMPLE_BITS-1:0] s);
			int n;
			int delta;
			if (s <= tolerance)
				return '0;
			n = (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
			for (int i = 0; i < n; i++) begin
				delta = int'(s) - int'(levels[i]);
				if (delta < 0)
					delta = -delta;
				if (delta <= int'(tolerance))
					return key_char(i);
			end
			return '0;
		endfunction

		// Apply one accepted item and queue the result it produces
		function void take_item(logic [CMD_W-1:0] cmd, logic [SAMPLE_BITS-1:0] s,
				logic [EIDX_W-1:0] idx, logic [SAMPLE_BITS-1:0] val);
			logic [CODE_W-1:0] k;
			logic [CODE_W-1:0] code;
			key_result_t       r;
			code = '0;
			case (cmd)
				CMD_SCAN: begin
					k = decode_sample(s);
					case (key_phase)
						PH_IDLE: begin
							if (k != '0) begin
								latched_key   = k;
								debounce_left = debounce_ticks;
								hold_count    = '0;
								key_phase     = PH_DEBOUNCE;
							end
						end
						PH_DEBOUNCE: begin
							if (k != latched_key)
								key_phase = PH_IDLE;
							else if (debounce_left != '0)
								debounce_left = debounce_left - 1'b1;
							else begin
								key_phase  = PH_HELD;
								hold_count = '0;
							end
						end
						PH_HELD: begin
							if (k != latched_key)
								key_phase = PH_RELEASED;
							else if (hold_count != TICK_MAX)
								hold_count = hold_count + 1'b1;
						end
						PH_RELEASED: ;
						default: key_phase = PH_IDLE;
					endcase
				end
				CMD_READ: begin
					if (key_phase == PH_RELEASED) begin
						key_phase = PH_READ;
						code      = latched_key;
						if (long_en && hold_count > long_ticks)
							code = code | LONG_BIT;
					end
				end
				CMD_WRITE: levels[idx] = val;
				default: ;
			endcase
			r.code        = code;
			r.phase_after = key_phase;
			expected_keys.push_back(r);
		endfunction

		function void flag(string what, int want, int got);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
		endfunction

		function void match_result(logic [CODE_W-1:0] code, logic [PHASE_W-1:0] st);
			key_result_t want;
			if (expected_keys.size() == 0) begin
				flag("result with nothing pending", 0, code);
				return;
			end
			want = expected_keys.pop_front();
			if (code !== want.code)
				flag("key_code", want.code, code);
			if (st !== want.phase_after)
				flag("machine_state", want.phase_after, st);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [CMD_W-1:0]       command;
	logic [SAMPLE_BITS-1:0] sample;
	logic [EIDX_W-1:0]      entry_index;
	logic [SAMPLE_BITS-1:0] entry_value;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CODE_W-1:0]      key_code;
	logic [PHASE_W-1:0]     machine_state;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	keypad_shadow shadow;
	int           items;
	int           burst_left;
	bit           steady;
	int           cycles;
	int           rx_cycle = 0;
	int           rx_mode  = 0;
	int           rx_stall = 0;

	// Phase settings: key count, tolerance, debounce, long enable, long ticks
	int plan_kc     [N_PHASES] = '{16, 0, 31, 16, 10, 5, 16};
	int plan_tol    [N_PHASES] = '{20, 0, 60, 4095, 100, 7, 1};
	int plan_deb    [N_PHASES] = '{4, 0, 1, 255, 2, 0, 3};
	int plan_lpe    [N_PHASES] = '{0, 1, 1, 1, 1, 1, 0};
	int plan_lpt    [N_PHASES] = '{100, 255, 3, 0, 5, 1, 0};
	int plan_items  [N_PHASES] = '{150, 60, 150, 50, 150, 120, 100};
	int plan_steady [N_PHASES] = '{0, 1, 0, 0, 1, 0, 0};

	resistor_ladder_keypad_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.sample       (sample),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_code     (key_code),
		.machine_state(machine_state),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: always ready, coin flip, or runs of stalls; mode changes now and then
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: out_ready = 1'b1;
			1: out_ready = ($urandom_range(0, 1) == 1);
			default: begin
				if (rx_stall != 0) begin
					rx_stall--;
					out_ready = 1'b0;
				end else begin
					out_ready = 1'b1;
					if ($urandom_range(0, 5) == 0)
						rx_stall = $urandom_range(1, 10);
				end
			end
		endcase
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.match_result(key_code, machine_state);
	end

	// Sender pacing: bursts of transfers separated by idle gaps
	task automatic pace_sender();
		if (steady)
			return;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk) in_valid = 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	// One input transfer; valid stays up if the next item follows directly
	task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_BITS-1:0] s,
			input logic [EIDX_W-1:0] idx, input logic [SAMPLE_BITS-1:0] val);
		@(negedge clk);
		command     = cmd;
		sample      = s;
		entry_index = idx;
		entry_value = val;
		in_valid    = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		shadow.take_item(cmd, s, idx, val);
		items++;
		pace_sender();
	endtask

	// Hold off the sender until every pending result has come back
	task automatic wait_drain();
		@(negedge clk) in_valid = 1'b0;
		while (shadow.expected_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// APB write: setup then access
	task automatic reg_write(input logic [2:0] idx, input int v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = APB_DW'(v);
		@(negedge clk) penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		shadow.set_reg(idx, APB_DW'(v));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apply_settings(input int kc, input int tol, input int deb,
			input int lpe, input int lpt);
		reg_write(REG_KEY_COUNT, kc);
		reg_write(REG_TOLERANCE, tol);
		reg_write(REG_DEBOUNCE, deb);
		reg_write(REG_LONG_EN, lpe);
		reg_write(REG_LONG_TICKS, lpt);
	endtask

	// Spread key levels over the ADC range with some jitter
	task automatic fill_levels();
		for (int i = 0; i < MAX_KEYS; i++)
			push_item(CMD_WRITE, SAMPLE_BITS'($urandom), EIDX_W'(i),
				SAMPLE_BITS'(i * 250 + $urandom_range(30, 150)));
	endtask

	// Sample close to a key level, within tolerance as far as the range allows
	function automatic logic [SAMPLE_BITS-1:0] near_level(logic [SAMPLE_BITS-1:0] lvl,
			logic [SAMPLE_BITS-1:0] tol);
		int span;
		int v;
		span = (tol > 30) ? 30 : int'(tol);
		v = int'(lvl) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_BITS'(v);
	endfunction

	// Press, debounce, hold, release, read, then back to idle
	task automatic key_sequence();
		int                     n_keys;
		int                     k;
		int                     presses;
		int                     holds;
		logic [SAMPLE_BITS-1:0] lvl;
		n_keys = (shadow.key_count > MAX_KEYS) ? MAX_KEYS : int'(shadow.key_count);
		k = (n_keys == 0) ? $urandom_range(0, MAX_KEYS - 1) : $urandom_range(0, n_keys - 1);
		lvl = shadow.levels[k];
		// long debounce settings only get a partial press
		presses = (shadow.debounce_ticks > 20) ? $urandom_range(1, 30)
			: int'(shadow.debounce_ticks) + 2;
		holds = $urandom_range(0, 8);
		for (int i = 0; i < presses + holds; i++) begin
			if ($urandom_range(0, 31) == 0)
				push_item(CMD_SCAN, SAMPLE_BITS'($urandom), EIDX_W'($urandom),
					SAMPLE_BITS'($urandom));
			else
				push_item(CMD_SCAN, near_level(lvl, shadow.tolerance), EIDX_W'($urandom),
					SAMPLE_BITS'($urandom));
		end
		// release: mostly a quiet line, sometimes another key
		if ($urandom_range(0, 3) == 0)
			push_item(CMD_SCAN, SAMPLE_BITS'($urandom), EIDX_W'($urandom),
				SAMPLE_BITS'($urandom));
		else
			push_item(CMD_SCAN, SAMPLE_BITS'($urandom_range(0, shadow.tolerance)),
				EIDX_W'($urandom), SAMPLE_BITS'($urandom));
		repeat ($urandom_range(1, 2))
			push_item(CMD_READ, SAMPLE_BITS'($urandom), EIDX_W'($urandom),
				SAMPLE_BITS'($urandom));
		push_item(CMD_SCAN, SAMPLE_BITS'($urandom), EIDX_W'($urandom), SAMPLE_BITS'($urandom));
	endtask

	initial begin
		int                     start;
		int                     k;
		int                     pick;
		logic [SAMPLE_BITS-1:0] lvl;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_SCAN;
		sample      = '0;
		entry_index = '0;
		entry_value = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		items       = 0;
		cycles      = 0;
		burst_left  = 1;
		steady      = 1'b0;
		shadow      = new();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: no debounce, long flag on any hold
		apply_settings(16, 20, 0, 1, 0);
		push_item(CMD_READ, '0, '0, '0);                      // read with nothing latched
		push_item(2'd3, 12'hFFF, 4'hF, 12'hFFF);              // unused command
		push_item(CMD_WRITE, '0, 4'd15, 12'hFFF);
		push_item(CMD_WRITE, '0, 4'd0, 12'd100);
		push_item(CMD_WRITE, '0, 4'd10, 12'd2000);
		push_item(CMD_WRITE, '0, 4'd3, 12'd0);
		push_item(CMD_SCAN, 12'd0, '0, '0);                   // quiet line
		push_item(CMD_SCAN, 12'hFFF, '0, '0);                 // top key pressed
		push_item(CMD_SCAN, 12'hFFF, '0, '0);                 // held
		push_item(CMD_SCAN, 12'd4090, '0, '0);                // jitter, still held
		push_item(CMD_SCAN, 12'd20, '0, '0);                  // sample equal to tolerance
		push_item(CMD_SCAN, 12'hFFF, '0, '0);                 // ignored while released
		push_item(CMD_READ, '0, '0, '0);                      // long hold flagged
		push_item(CMD_READ, '0, '0, '0);                      // second read gets nothing
		push_item(CMD_SCAN, 12'hFFF, '0, '0);                 // back to idle
		push_item(CMD_SCAN, 12'd100, '0, '0);                 // key 0 starts debounce
		push_item(CMD_SCAN, 12'd2000, '0, '0);                // other key breaks debounce
		push_item(CMD_SCAN, 12'd2010, '0, '0);
		push_item(CMD_SCAN, 12'd2010, '0, '0);
		push_item(CMD_SCAN, 12'd100, '0, '0);                 // change of key releases
		push_item(CMD_READ, '0, '0, '0);
		push_item(CMD_SCAN, 12'd0, '0, '0);
		wait_drain();

		// Random phases, one register setting each
		for (int p = 0; p < N_PHASES; p++) begin
			apply_settings(plan_kc[p], plan_tol[p], plan_deb[p], plan_lpe[p], plan_lpt[p]);
			steady = plan_steady[p];
			start  = items;
			if (p == 0 || $urandom_range(0, 1) == 1)
				fill_levels();
			while (items - start < plan_items[p]) begin
				pick = $urandom_range(0, 9);
				if (pick <= 6)
					key_sequence();
				else if (pick <= 8)
					push_item(CMD_W'($urandom), SAMPLE_BITS'($urandom), EIDX_W'($urandom),
						SAMPLE_BITS'($urandom));
				else
					push_item(CMD_WRITE, SAMPLE_BITS'($urandom), EIDX_W'($urandom),
						SAMPLE_BITS'($urandom));
				if ($urandom_range(0, 149) == 0)
					wait_drain();
			end
			wait_drain();
		end

		// Hold long enough for the hold counter to saturate
		steady = 1'b0;
		apply_settings(16, 20, 0, 1, 254);
		k = $urandom_range(1, MAX_KEYS - 1);
		push_item(CMD_WRITE, '0, EIDX_W'(k), SAMPLE_BITS'(1000 + k * 150));
		lvl = shadow.levels[k];
		repeat (262)
			push_item(CMD_SCAN, lvl, EIDX_W'($urandom), SAMPLE_BITS'($urandom));
		push_item(CMD_SCAN, '0, '0, '0);
		push_item(CMD_READ, '0, '0, '0);
		push_item(CMD_SCAN, '0, '0, '0);
		wait_drain();

		if (shadow.errors == 0 && shadow.expected_keys.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
